>>> hdl/lru_pkg.sv
// Shared types and constants for the LRU page replacement unit.
package lru_pkg;

	localparam int FRAMES = 8;
	localparam int IDX_W  = $clog2(FRAMES);
	localparam int OCC_W  = $clog2(FRAMES + 1);
	localparam int PAGE_W = 8;
	localparam int CAP_W  = 4;
	localparam int RANK_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3);

	// Command codes
	localparam logic CMD_REF   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic              command;
		logic [PAGE_W-1:0] page;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [RANK_W-1:0] rank;
		logic [PAGE_W-1:0] entry_page;
		logic              last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_LIST
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic update;
		logic emit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rank_last;
	} ctrl_sts_t;

endpackage

>>> hdl/lru_ctrl.sv
// Controller state machine for the LRU page replacement unit.
module lru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_command,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lru_pkg::ctrl_cmd_t cmd,
	input  lru_pkg::ctrl_sts_t sts
);

	lru_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != lru_pkg::ST_IDLE);
	assign rsp_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			lru_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_command == lru_pkg::CMD_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d     = lru_pkg::ST_LOOKUP;
					end
				end
			end
			lru_pkg::ST_LOOKUP: begin
				cmd.update = 1'b1;
				state_d    = lru_pkg::ST_LIST;
			end
			lru_pkg::ST_LIST: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					if (sts.rank_last) begin
						state_d = lru_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = lru_pkg::ST_IDLE;
			end
		endcase
	end

	// Output valid: set on load, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The final listing entry returns the controller to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.rank_last |=> state_q == lru_pkg::ST_IDLE)
		else $error("listing did not end after final entry");

endmodule

>>> hdl/lru_dp.sv
// Datapath for the LRU page replacement unit: recency list, lookup and listing.
module lru_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lru_pkg::CAP_W-1:0]      cfg_wr_data,
	input  logic [lru_pkg::PAGE_W-1:0]     req_page,
	input  lru_pkg::ctrl_cmd_t             cmd,
	output lru_pkg::ctrl_sts_t             sts,
	output lru_pkg::rsp_t                  rsp
);

	logic [lru_pkg::PAGE_W-1:0] entry_q [lru_pkg::FRAMES];
	logic [lru_pkg::PAGE_W-1:0] page_q;
	logic [lru_pkg::CAP_W-1:0]  cap_q;
	logic [lru_pkg::OCC_W-1:0]  occ_q;
	logic [lru_pkg::IDX_W-1:0]  rank_q;
	logic                       hit_q;
	logic                       ev_valid_q;
	logic [lru_pkg::PAGE_W-1:0] ev_page_q;
	lru_pkg::rsp_t              rsp_q;

	logic [lru_pkg::FRAMES-1:0] match;
	logic                       hit;
	logic [lru_pkg::IDX_W-1:0]  pos;
	logic [lru_pkg::OCC_W-1:0]  cap_eff;
	logic                       evict;
	logic [lru_pkg::OCC_W-1:0]  shift_lim;
	logic [lru_pkg::OCC_W-1:0]  occ_m1;
	logic [lru_pkg::IDX_W-1:0]  rd_idx;
	logic [lru_pkg::PAGE_W-1:0] rd_data;

	assign occ_m1 = occ_q - lru_pkg::OCC_W'(1);

	// Effective capacity, zero acts as one, large values clamp to the frame count
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lru_pkg::OCC_W'(1);
		end else if (lru_pkg::OCC_W'(cap_q) > lru_pkg::OCC_W'(lru_pkg::FRAMES)) begin
			cap_eff = lru_pkg::OCC_W'(lru_pkg::FRAMES);
		end else begin
			cap_eff = lru_pkg::OCC_W'(cap_q);
		end
	end

	// Parallel compare over resident entries, lowest matching position wins
	always_comb begin
		pos = '0;
		for (int i = 0; i < lru_pkg::FRAMES; i++) begin
			match[i] = (entry_q[i] == page_q) && (lru_pkg::OCC_W'(i) < occ_q);
		end
		for (int i = lru_pkg::FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				pos = lru_pkg::IDX_W'(i);
			end
		end
	end

	assign hit   = |match;
	assign evict = !hit && (occ_q >= cap_eff) && (occ_q != '0);

	// Last position that takes its upper neighbor
	always_comb begin
		priority if (hit) begin
			shift_lim = lru_pkg::OCC_W'(pos);
		end else if (evict) begin
			shift_lim = occ_m1;
		end else begin
			shift_lim = occ_q;
		end
	end

	// Single read port: least recent entry during lookup, listing rank otherwise
	assign rd_idx  = cmd.update ? occ_m1[lru_pkg::IDX_W-1:0] : rank_q;
	assign rd_data = entry_q[rd_idx];

	assign sts.rank_last = (lru_pkg::OCC_W'(rank_q) == occ_m1);
	assign rsp           = rsp_q;

	// Recency list shift, no reset
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			entry_q[0] <= page_q;
			for (int i = 1; i < lru_pkg::FRAMES; i++) begin
				if (lru_pkg::OCC_W'(i) <= shift_lim) begin
					entry_q[i] <= entry_q[i-1];
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_q <= req_page;
		end
		if (cmd.update) begin
			ev_page_q <= evict ? rd_data : '0;
		end
		if (cmd.emit) begin
			rsp_q.hit           <= hit_q;
			rsp_q.evicted_valid <= ev_valid_q;
			rsp_q.evicted_page  <= ev_page_q;
			rsp_q.rank          <= lru_pkg::RANK_W'(rank_q);
			rsp_q.entry_page    <= rd_data;
			rsp_q.last          <= sts.rank_last;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= lru_pkg::CAP_RESET;
			occ_q      <= '0;
			rank_q     <= '0;
			hit_q      <= 1'b0;
			ev_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.clear) begin
				occ_q <= '0;
			end else if (cmd.update) begin
				hit_q      <= hit;
				ev_valid_q <= evict;
				rank_q     <= '0;
				if (!hit && !evict) begin
					occ_q <= occ_q + lru_pkg::OCC_W'(1);
				end
			end else if (cmd.emit) begin
				rank_q <= rank_q + lru_pkg::IDX_W'(1);
			end
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= lru_pkg::OCC_W'(lru_pkg::FRAMES))
		else $error("occupancy above frame count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> occ_q == '0)
		else $error("clear left pages resident");

	a_ref_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> occ_q != '0)
		else $error("reference left the set empty");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit_q && ev_valid_q))
		else $error("hit and eviction on one reference");

endmodule

>>> hdl/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit.
//
//  Channel   Signals                          Direction   Moves
//  req       req_valid, req_stall, req        in          command and page
//  rsp       rsp_valid, rsp_stall, rsp        out         one listing entry
//  cfg       cfg_wr_en, cfg_wr_data           in          capacity write
//
// A reference passes through capture, then the parallel lookup and list
// update, then one listing entry per resident page after it (1..8) through
// the single list read port. A clear is taken in idle without leaving it.
// req_stall is high from capture until the last entry is loaded into the
// output register; a stalled output holds the listing. Reset empties the set
// and sets the capacity to 3.
module lru_page_replacement_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lru_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lru_pkg::rsp_t             rsp,
	input  logic                      cfg_wr_en,
	input  logic [lru_pkg::CAP_W-1:0] cfg_wr_data
);

	lru_pkg::ctrl_cmd_t cmd;
	lru_pkg::ctrl_sts_t sts;

	lru_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	lru_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_page    (req.page),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule
